// ----- src/itf_pkg.sv -----
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types and constants for the increasing triplet finder.
// ----------------------------------------------------------------------------
`default_nettype none

package itf_pkg;

  localparam int VAL_W           = 31;
  localparam int MAX_LEN_DEFAULT = 1024;

  // One stored element: its value and, when smaller than it, the minimum of the values before it.
  typedef struct packed {
    logic             low_valid;
    logic [VAL_W-1:0] low;
    logic [VAL_W-1:0] value;
  } itf_entry_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_WALK,
    S_EMIT
  } itf_state_t;

endpackage

`default_nettype wire

// ----- src/itf_ram.sv -----
// ----------------------------------------------------------------------------
// itf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/increasing_triplet_finder_core.sv -----
// ----------------------------------------------------------------------------
// increasing_triplet_finder_core: one item per cycle while loading the sequence.
// After the last item, with n >= 3 items stored, the store is walked backward, one
// entry read a cycle; with fewer than three stored the walk is skipped. Input stalls
// until the result is out.
// A result still waiting on the output holds the next one in the emit state.
// Reset (synchronous) clears counters, running minimum and output valid; store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module increasing_triplet_finder_core #(
  parameter int MAX_LEN = itf_pkg::MAX_LEN_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [itf_pkg::VAL_W-1:0] value,
  input  logic                     last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     found,
  output logic [itf_pkg::VAL_W-1:0] smallest,
  output logic [itf_pkg::VAL_W-1:0] middle,
  output logic [itf_pkg::VAL_W-1:0] largest,
  output logic                     overflow
);

  import itf_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  itf_state_t state, state_next;

  logic [CW-1:0]    count;
  logic [VAL_W-1:0] running_min;
  logic             dropped;

  logic [AW-1:0]    rd_ptr;
  logic             issuing;
  logic             first_pend;
  logic             dv;
  logic             dv_first;
  logic             dv_end;

  logic [VAL_W-1:0] hi;
  logic             res_found;
  logic [VAL_W-1:0] res_s;
  logic [VAL_W-1:0] res_m;
  logic [VAL_W-1:0] res_l;

  logic             accept;
  logic             store_ok;
  logic [VAL_W-1:0] rm_eff;
  logic [CW-1:0]    count_inc;
  logic             n_ge3;
  logic             emit_go;
  itf_entry_t       wentry;
  itf_entry_t       rd_entry;
  logic             hit;

  assign accept    = in_valid && in_ready;
  assign store_ok  = (count < CW'(MAX_LEN));
  assign rm_eff    = (count == '0) ? value : running_min;
  assign count_inc = count + CW'(store_ok);
  assign n_ge3     = (count_inc >= CW'(3));

  always_comb begin
    wentry.value     = value;
    wentry.low_valid = (rm_eff < value);
    wentry.low       = wentry.low_valid ? rm_eff : '0;
  end

  itf_ram #(
    .WIDTH($bits(itf_entry_t)),
    .DEPTH(MAX_LEN)
  ) u_store (
    .clk  (clk),
    .we   (accept && store_ok),
    .waddr(count[AW-1:0]),
    .wdata(wentry),
    .re   (issuing),
    .raddr(rd_ptr),
    .rdata(rd_entry)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (accept && last) begin
          state_next = n_ge3 ? S_WALK : S_EMIT;
        end
      end
      S_WALK: begin
        if (dv && dv_end) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    emit_go  = 1'b0;
    case (state)
      S_LOAD:  in_ready = 1'b1;
      S_WALK:  in_ready = 1'b0;
      S_EMIT:  emit_go  = !out_valid || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  // middle candidate: later max larger and an earlier smaller value exists
  assign hit = dv && !dv_first && (hi > rd_entry.value) && rd_entry.low_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      count       <= '0;
      running_min <= '0;
      dropped     <= 1'b0;
      issuing     <= 1'b0;
      first_pend  <= 1'b0;
      dv          <= 1'b0;
      dv_first    <= 1'b0;
      dv_end      <= 1'b0;
      rd_ptr      <= '0;
      out_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      dv       <= issuing;
      dv_first <= issuing && first_pend;
      dv_end   <= issuing && (rd_ptr == '0);

      if (accept) begin
        if (store_ok) begin
          count       <= count_inc;
          running_min <= (value < rm_eff) ? value : rm_eff;
        end else begin
          dropped <= 1'b1;
        end
        if (last && n_ge3) begin
          issuing    <= 1'b1;
          first_pend <= 1'b1;
          rd_ptr     <= AW'(count_inc - CW'(1));
        end
      end

      if (issuing) begin
        rd_ptr     <= rd_ptr - AW'(1);
        first_pend <= 1'b0;
        if (rd_ptr == '0) begin
          issuing <= 1'b0;
        end
      end

      if (emit_go) begin
        out_valid   <= 1'b1;
        count       <= '0;
        running_min <= '0;
        dropped     <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk datapath and output payload
  always_ff @(posedge clk) begin
    if (accept && last) begin
      res_found <= 1'b0;
      res_s     <= '0;
      res_m     <= '0;
      res_l     <= '0;
    end
    if (dv) begin
      if (dv_first || (rd_entry.value > hi)) begin
        hi <= rd_entry.value;
      end
    end
    // later hits have smaller indexes and win
    if (hit) begin
      res_found <= 1'b1;
      res_s     <= rd_entry.low;
      res_m     <= rd_entry.value;
      res_l     <= hi;
    end
    if (emit_go) begin
      found    <= res_found;
      smallest <= res_s;
      middle   <= res_m;
      largest  <= res_l;
      overflow <= dropped;
    end
  end

endmodule

`default_nettype wire

// ----- src/itf_checker.sv -----
// ----------------------------------------------------------------------------
// itf_checker
// Port-level checks for the increasing triplet finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     found,
  input logic [itf_pkg::VAL_W-1:0] smallest,
  input logic [itf_pkg::VAL_W-1:0] middle,
  input logic [itf_pkg::VAL_W-1:0] largest,
  input logic                     overflow
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (smallest == '0 && middle == '0 && largest == '0))
    else $error("triplet fields nonzero when not found");

  a_found_ordered: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (smallest < middle && middle < largest))
    else $error("reported triplet is not strictly increasing");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(found) && $stable(smallest)
      && $stable(middle) && $stable(largest) && $stable(overflow)))
    else $error("stalled result changed");

endmodule

bind increasing_triplet_finder_core itf_checker u_itf_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .found    (found),
  .smallest (smallest),
  .middle   (middle),
  .largest  (largest),
  .overflow (overflow)
);

`default_nettype wire
